### hw/rtl/tcl_pkg.sv
`timescale 1ns / 1ps
// tcl_pkg: shared types, constants and helpers for the text cursor layout block
// no dependencies; used by the interfaces, tcl_step and text_cursor_layout

package tcl_pkg;

  // coordinate width of reported positions; cursor state keeps one more bit
  localparam int COORD_BITS = 16;
  localparam int ST_W       = COORD_BITS + 1;

  // fixed widths of the configuration registers
  localparam int CFG_COORD_W = 16;
  localparam int CW_W        = 4;
  localparam int CH_W        = 6;
  localparam int GAP_W       = 8;
  localparam int CODE_W      = 8;
  localparam int CFG_IDX_W   = 3;

  // working width for sums and compares: covers state, registers and small offsets
  localparam int CMP_W = ((COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W) + 2;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  localparam logic [CODE_W-1:0] CODE_NEWLINE = CODE_W'(10);
  localparam logic [CODE_W-1:0] CODE_TAB     = CODE_W'(9);
  localparam int                TAB_CELLS    = 4;

  // register reset values
  localparam logic [CFG_COORD_W-1:0] START_X_RST = '0;
  localparam logic [CFG_COORD_W-1:0] START_Y_RST = '0;
  localparam logic [CFG_COORD_W-1:0] LIMIT_X_RST = CFG_COORD_W'(640);
  localparam logic [CFG_COORD_W-1:0] LIMIT_Y_RST = CFG_COORD_W'(480);
  localparam logic [CW_W-1:0]        CELL_W_RST  = CW_W'(8);
  localparam logic [CH_W-1:0]        CELL_H_RST  = CH_W'(16);
  localparam logic [GAP_W-1:0]       GAP_RST     = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_LIMIT_X  = 3'd2,
    REG_LIMIT_Y  = 3'd3,
    REG_GLYPH_W  = 3'd4,
    REG_GLYPH_H  = 3'd5,
    REG_LINE_GAP = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_COORD_W-1:0] start_x;
    logic [CFG_COORD_W-1:0] start_y;
    logic [CFG_COORD_W-1:0] limit_x;
    logic [CFG_COORD_W-1:0] limit_y;
    logic [CW_W-1:0]        glyph_w;
    logic [CH_W-1:0]        glyph_h;
    logic [GAP_W-1:0]       line_gap;
  } cfg_t;

  typedef struct packed {
    logic [ST_W-1:0] cur_x;
    logic [ST_W-1:0] cur_y;
    logic            stopped;
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              first_of_string;
    logic              last_of_string;
  } item_t;

  typedef struct packed {
    logic                  draw_valid;
    logic [COORD_BITS-1:0] glyph_x;
    logic [COORD_BITS-1:0] glyph_y;
    logic [CODE_W-1:0]     glyph_code;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  clipped;
    logic                  end_of_string;
  } result_t;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [CMP_W-1:0] v);
    logic [COORD_BITS-1:0] r;
    r = (v > CMP_W'(COORD_MAX)) ? COORD_MAX : v[COORD_BITS-1:0];
    return r;
  endfunction

endpackage

### hw/rtl/tcl_if.sv
`timescale 1ns / 1ps
// channel interfaces of the text cursor layout block: characters, results, register writes
// depends on tcl_pkg

interface tcl_char_if;
  logic                      valid;
  logic                      ready;
  logic [tcl_pkg::CODE_W-1:0] char_code;
  logic                      first_of_string;
  logic                      last_of_string;

  modport source (output valid, char_code, first_of_string, last_of_string, input ready);
  modport sink   (input valid, char_code, first_of_string, last_of_string, output ready);
endinterface

interface tcl_glyph_if;
  logic                           valid;
  logic                           ready;
  logic                           draw_valid;
  logic [tcl_pkg::COORD_BITS-1:0] glyph_x;
  logic [tcl_pkg::COORD_BITS-1:0] glyph_y;
  logic [tcl_pkg::CODE_W-1:0]     glyph_code;
  logic [tcl_pkg::COORD_BITS-1:0] cursor_x;
  logic [tcl_pkg::COORD_BITS-1:0] cursor_y;
  logic                           clipped;
  logic                           end_of_string;

  modport source (output valid, draw_valid, glyph_x, glyph_y, glyph_code, cursor_x,
                  cursor_y, clipped, end_of_string, input ready);
  modport sink   (input valid, draw_valid, glyph_x, glyph_y, glyph_code, cursor_x,
                  cursor_y, clipped, end_of_string, output ready);
endinterface

interface tcl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcl_pkg::CFG_IDX_W-1:0]   index;
  logic [tcl_pkg::CFG_COORD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/tcl_step.sv
`timescale 1ns / 1ps
// tcl_step: placement of one character from the current cursor state and registers
// purely combinational; depends on tcl_pkg

module tcl_step (
  input  tcl_pkg::cfg_t    cfg,
  input  tcl_pkg::state_t  st,
  input  tcl_pkg::item_t   item,
  output tcl_pkg::state_t  nxt,
  output tcl_pkg::result_t res
);
  import tcl_pkg::*;

  logic [CMP_W-1:0] base_x, base_y, start_x_w, cw_w, ch_w, lim_x_w, lim_y_w;
  logic [CMP_W-1:0] nl_y, tab_x, x, y, x_next;
  logic             stop_in, wrap_glyph, wrap_tab, stop_new, draw;
  logic             is_nl, is_tab;

  function automatic logic below_bottom(input logic [CMP_W-1:0] yy,
                                        input logic [CMP_W-1:0] ch,
                                        input logic [CMP_W-1:0] lim);
    return (yy + ch) > lim;
  endfunction

  always_comb begin
    start_x_w = CMP_W'(cfg.start_x);
    cw_w      = CMP_W'(cfg.glyph_w);
    ch_w      = CMP_W'(cfg.glyph_h);
    lim_x_w   = CMP_W'(cfg.limit_x);
    lim_y_w   = CMP_W'(cfg.limit_y);

    // a first character restarts from the start position
    base_x  = item.first_of_string ? start_x_w : CMP_W'(st.cur_x);
    base_y  = item.first_of_string ? CMP_W'(cfg.start_y) : CMP_W'(st.cur_y);
    stop_in = item.first_of_string ? 1'b0 : st.stopped;

    is_nl  = (item.char_code == CODE_NEWLINE);
    is_tab = (item.char_code == CODE_TAB);

    nl_y       = base_y + ch_w + CMP_W'(cfg.line_gap);
    tab_x      = base_x + cw_w * CMP_W'(TAB_CELLS);
    wrap_glyph = (base_x + cw_w) > lim_x_w;
    wrap_tab   = (tab_x + cw_w) > lim_x_w;

    x        = base_x;
    y        = base_y;
    stop_new = 1'b0;
    if (is_nl) begin
      x        = start_x_w;
      y        = nl_y;
      stop_new = below_bottom(nl_y, ch_w, lim_y_w);
    end else if (is_tab) begin
      x        = wrap_tab ? start_x_w : tab_x;
      y        = wrap_tab ? nl_y : base_y;
      stop_new = below_bottom(y, ch_w, lim_y_w);
    end else if (wrap_glyph) begin
      x        = start_x_w;
      y        = nl_y;
      stop_new = below_bottom(nl_y, ch_w, lim_y_w);
    end

    draw   = !stop_in && !is_nl && !is_tab && !stop_new;
    x_next = draw ? x + cw_w : x;

    // a stopped string leaves the cursor where it was
    if (stop_in) begin
      nxt.cur_x   = base_x[ST_W-1:0];
      nxt.cur_y   = base_y[ST_W-1:0];
      nxt.stopped = 1'b1;
    end else begin
      nxt.cur_x   = x_next[ST_W-1:0];
      nxt.cur_y   = y[ST_W-1:0];
      nxt.stopped = stop_new;
    end

    res.draw_valid    = draw;
    res.glyph_x       = draw ? sat_coord(x) : '0;
    res.glyph_y       = draw ? sat_coord(y) : '0;
    res.glyph_code    = draw ? item.char_code : '0;
    res.cursor_x      = sat_coord(CMP_W'(nxt.cur_x));
    res.cursor_y      = sat_coord(CMP_W'(nxt.cur_y));
    res.clipped       = nxt.stopped;
    res.end_of_string = item.last_of_string;
  end

endmodule

### hw/rtl/text_cursor_layout.sv
`timescale 1ns / 1ps
// text_cursor_layout: top level; input register, cursor state, result register, registers
// depends on tcl_pkg, tcl_if and tcl_step
// a character enters the input register, then its result the result register
// throughput: one character per cycle while glyphs.ready; each update is one tcl_step pass
// reset: synchronous; cursor (0,0), not stopped, registers at their defaults, no results held
// register writes are taken in every cycle

module text_cursor_layout (
  input  logic         clk,
  input  logic         rst,
  tcl_char_if.sink     chars,
  tcl_glyph_if.source  glyphs,
  tcl_cfg_if.sink      cfg
);
  import tcl_pkg::*;

  cfg_t    regs;
  state_t  state, state_next;
  item_t   s1_item, s1_in;
  logic    s1_valid;
  result_t out_res, step_res;
  logic    out_valid;
  logic    advance;

  assign s1_in.char_code       = chars.char_code;
  assign s1_in.first_of_string = chars.first_of_string;
  assign s1_in.last_of_string  = chars.last_of_string;

  // item moves on when the result register is free or being emptied
  assign advance     = s1_valid && (!out_valid || glyphs.ready);
  assign chars.ready = !s1_valid || advance;
  assign cfg.ready   = 1'b1;

  tcl_step u_step (
    .cfg  (regs),
    .st   (state),
    .item (s1_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_x  <= START_X_RST;
      regs.start_y  <= START_Y_RST;
      regs.limit_x  <= LIMIT_X_RST;
      regs.limit_y  <= LIMIT_Y_RST;
      regs.glyph_w  <= CELL_W_RST;
      regs.glyph_h  <= CELL_H_RST;
      regs.line_gap <= GAP_RST;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_START_X:  regs.start_x  <= cfg.data;
        REG_START_Y:  regs.start_y  <= cfg.data;
        REG_LIMIT_X:  regs.limit_x  <= cfg.data;
        REG_LIMIT_Y:  regs.limit_y  <= cfg.data;
        REG_GLYPH_W:  regs.glyph_w  <= cfg.data[CW_W-1:0];
        REG_GLYPH_H:  regs.glyph_h  <= cfg.data[CH_W-1:0];
        REG_LINE_GAP: regs.line_gap <= cfg.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (chars.valid && chars.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (glyphs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_item <= s1_in;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign glyphs.valid         = out_valid;
  assign glyphs.draw_valid    = out_res.draw_valid;
  assign glyphs.glyph_x       = out_res.glyph_x;
  assign glyphs.glyph_y       = out_res.glyph_y;
  assign glyphs.glyph_code    = out_res.glyph_code;
  assign glyphs.cursor_x      = out_res.cursor_x;
  assign glyphs.cursor_y      = out_res.cursor_y;
  assign glyphs.clipped       = out_res.clipped;
  assign glyphs.end_of_string = out_res.end_of_string;

  // a drawn glyph never comes from a stopped string
  a_draw_not_clipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.draw_valid |-> !out_res.clipped)
    else $error("glyph drawn while clipped");

  // no glyph means zeroed glyph fields
  a_no_draw_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.draw_valid |->
      out_res.glyph_x == '0 && out_res.glyph_y == '0 && out_res.glyph_code == '0)
    else $error("glyph fields set without a draw");

  // control characters are never drawn
  a_ctrl_not_drawn: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.draw_valid |->
      out_res.glyph_code != CODE_NEWLINE && out_res.glyph_code != CODE_TAB)
    else $error("newline or tab drawn as a glyph");

  // an item leaving the input register always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost on advance");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid && !state.stopped)
    else $error("control state not cleared by reset");

endmodule

### bench/tcl_layout_checker.sv
`timescale 1ns / 1ps
// tcl_layout_checker: watches the character, glyph and register channels of text_cursor_layout,
// keeps its own cursor and register copy, and compares every glyph transaction in order
// depends on tcl_pkg and tcl_if

module tcl_layout_checker (
  input  logic  clk,
  input  logic  rst,
  tcl_char_if   chars,
  tcl_glyph_if  glyphs,
  tcl_cfg_if    cfg,
  output int    errors,
  output int    outstanding,
  output int    drawn_seen,
  output int    clipped_seen
);

  import tcl_pkg::*;

  logic [CFG_COORD_W-1:0] org_x, org_y, edge_x, edge_y;
  logic [CW_W-1:0]        adv_w;
  logic [CH_W-1:0]        row_h;
  logic [GAP_W-1:0]       gap_h;

  logic [ST_W-1:0] pos_x, pos_y;
  logic            halted;

  result_t pending_layouts[$];
  int      results_seen;

  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [31:0] v);
    return (v > 32'(COORD_MAX)) ? COORD_MAX : v[COORD_BITS-1:0];
  endfunction

  // advances the cursor for one character and returns the glyph transaction it should cause
  function automatic result_t place_char(input item_t it);
    logic [31:0] x, y, row_pitch;
    result_t     r;
    r = '0;
    if (it.first_of_string) begin
      pos_x  = ST_W'(org_x);
      pos_y  = ST_W'(org_y);
      halted = 1'b0;
    end
    x = 32'(pos_x);
    y = 32'(pos_y);
    row_pitch = 32'(row_h) + 32'(gap_h);
    if (!halted) begin
      if (it.char_code == CODE_NEWLINE) begin
        x = 32'(org_x);
        y = y + row_pitch;
        if (y + 32'(row_h) > 32'(edge_y)) halted = 1'b1;
      end else if (it.char_code == CODE_TAB) begin
        x = x + 32'(adv_w) * 32'(TAB_CELLS);
        if (x + 32'(adv_w) > 32'(edge_x)) begin
          x = 32'(org_x);
          y = y + row_pitch;
        end
        // the bottom test applies after a tab even without a wrap
        if (y + 32'(row_h) > 32'(edge_y)) halted = 1'b1;
      end else begin
        if (x + 32'(adv_w) > 32'(edge_x)) begin
          x = 32'(org_x);
          y = y + row_pitch;
          if (y + 32'(row_h) > 32'(edge_y)) halted = 1'b1;
        end
        if (!halted) begin
          r.draw_valid = 1'b1;
          r.glyph_x    = clamp_coord(x);
          r.glyph_y    = clamp_coord(y);
          r.glyph_code = it.char_code;
          x = x + 32'(adv_w);
        end
      end
      pos_x = x[ST_W-1:0];
      pos_y = y[ST_W-1:0];
    end
    r.cursor_x      = clamp_coord(32'(pos_x));
    r.cursor_y      = clamp_coord(32'(pos_y));
    r.clipped       = halted;
    r.end_of_string = it.last_of_string;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: glyph transaction %0d, %s mismatch: expected %0d, actual %0d",
               $time, results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    item_t   it;
    if (rst) begin
      org_x  = START_X_RST;
      org_y  = START_Y_RST;
      edge_x = LIMIT_X_RST;
      edge_y = LIMIT_Y_RST;
      adv_w  = CELL_W_RST;
      row_h  = CELL_H_RST;
      gap_h  = GAP_RST;
      pos_x  = '0;
      pos_y  = '0;
      halted = 1'b0;
      pending_layouts.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_START_X:  org_x  = cfg.data;
          REG_START_Y:  org_y  = cfg.data;
          REG_LIMIT_X:  edge_x = cfg.data;
          REG_LIMIT_Y:  edge_y = cfg.data;
          REG_GLYPH_W:  adv_w  = cfg.data[CW_W-1:0];
          REG_GLYPH_H:  row_h  = cfg.data[CH_W-1:0];
          REG_LINE_GAP: gap_h  = cfg.data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (glyphs.valid && glyphs.ready) begin
        got.draw_valid    = glyphs.draw_valid;
        got.glyph_x       = glyphs.glyph_x;
        got.glyph_y       = glyphs.glyph_y;
        got.glyph_code    = glyphs.glyph_code;
        got.cursor_x      = glyphs.cursor_x;
        got.cursor_y      = glyphs.cursor_y;
        got.clipped       = glyphs.clipped;
        got.end_of_string = glyphs.end_of_string;
        if (pending_layouts.size() == 0) begin
          errors++;
          $display("%0t: unexpected glyph transaction: expected none, actual %p", $time, got);
        end else begin
          want = pending_layouts.pop_front();
          check_field("draw_valid", 32'(want.draw_valid), 32'(got.draw_valid));
          check_field("glyph_x", 32'(want.glyph_x), 32'(got.glyph_x));
          check_field("glyph_y", 32'(want.glyph_y), 32'(got.glyph_y));
          check_field("glyph_code", 32'(want.glyph_code), 32'(got.glyph_code));
          check_field("cursor_x", 32'(want.cursor_x), 32'(got.cursor_x));
          check_field("cursor_y", 32'(want.cursor_y), 32'(got.cursor_y));
          check_field("clipped", 32'(want.clipped), 32'(got.clipped));
          check_field("end_of_string", 32'(want.end_of_string), 32'(got.end_of_string));
          if (want.draw_valid) drawn_seen++;
          if (want.clipped) clipped_seen++;
        end
        results_seen++;
      end
      if (chars.valid && chars.ready) begin
        it.char_code       = chars.char_code;
        it.first_of_string = chars.first_of_string;
        it.last_of_string  = chars.last_of_string;
        pending_layouts.push_back(place_char(it));
      end
    end
    outstanding <= pending_layouts.size();
  end

endmodule

### bench/tb_text_cursor_layout.sv
`timescale 1ns / 1ps
// tb_text_cursor_layout: drives characters and register writes into text_cursor_layout
// under changing idle patterns; depends on tcl_pkg, tcl_if, the block and tcl_layout_checker

module tb_text_cursor_layout;

  import tcl_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 70;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst;

  tcl_char_if  chars ();
  tcl_glyph_if glyphs ();
  tcl_cfg_if   cfg ();

  int errors, outstanding, drawn_seen, clipped_seen;
  int src_idle_pct, snk_idle_pct;
  int chars_sent, cfg_writes, quiet_cycles;

  text_cursor_layout uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .glyphs (glyphs),
    .cfg    (cfg)
  );

  tcl_layout_checker chk (
    .clk          (clk),
    .rst          (rst),
    .chars        (chars),
    .glyphs       (glyphs),
    .cfg          (cfg),
    .errors       (errors),
    .outstanding  (outstanding),
    .drawn_seen   (drawn_seen),
    .clipped_seen (clipped_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    glyphs.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // ends the run if no transaction moves on any channel for too long
  always @(posedge clk) begin
    if ((chars.valid && chars.ready) || (glyphs.valid && glyphs.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] pick_code();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return CODE_NEWLINE;
    if (roll < 24) return CODE_TAB;
    if (roll < 40) return CODE_W'($urandom);
    return CODE_W'($urandom_range(32, 126));
  endfunction

  // valid stays high between back-to-back characters and drops only on an idle cycle
  task automatic send_char(input logic [CODE_W-1:0] code, input logic first, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid           <= 1'b1;
    chars.char_code       <= code;
    chars.first_of_string <= first;
    chars.last_of_string  <= last;
    do @(posedge clk); while (!chars.ready);
    chars_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_COORD_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg_writes++;
  endtask

  task automatic wait_for_drain();
    chars.valid <= 1'b0;
    cfg.valid   <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] sx, input logic [15:0] sy,
                               input logic [15:0] lx, input logic [15:0] ly,
                               input logic [15:0] cw, input logic [15:0] ch,
                               input logic [15:0] gap);
    wait_for_drain();
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_LIMIT_X, lx);
    write_reg(REG_LIMIT_Y, ly);
    write_reg(REG_GLYPH_W, cw);
    write_reg(REG_GLYPH_H, ch);
    write_reg(REG_LINE_GAP, gap);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly complete strings, with stray characters carrying random first/last marks
  task automatic random_text(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) send_char(pick_code(), i == 0, i == len - 1);
        sent += len;
      end else begin
        send_char(pick_code(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    int sx, sy;
    rst                   = 1'b1;
    chars.valid           = 1'b0;
    chars.char_code       = '0;
    chars.first_of_string = 1'b0;
    chars.last_of_string  = 1'b0;
    cfg.valid             = 1'b0;
    cfg.index             = '0;
    cfg.data              = '0;
    glyphs.ready          = 1'b0;
    src_idle_pct          = 6;
    snk_idle_pct          = 63;
    quiet_cycles          = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default registers, no first mark straight after reset
    send_char("A", 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(CODE_TAB, 1'b0, 1'b0);
    send_char(CODE_NEWLINE, 1'b0, 1'b0);
    send_char("B", 1'b0, 1'b1);

    // small grid: wrap, stop on a tab, ignored while stopped, a newline and a stop on a wrap
    apply_setting(16'd4, 16'd4, 16'd28, 16'd30, 16'd8, 16'd8, 16'd2);
    send_char("a", 1'b1, 1'b0);
    send_char("b", 1'b0, 1'b0);
    send_char("c", 1'b0, 1'b0);
    send_char("d", 1'b0, 1'b0);
    send_char(CODE_TAB, 1'b0, 1'b0);
    send_char("e", 1'b0, 1'b1);
    send_char("f", 1'b1, 1'b0);
    send_char(CODE_NEWLINE, 1'b0, 1'b0);
    send_char("g", 1'b0, 1'b0);
    send_char("h", 1'b0, 1'b0);
    send_char("i", 1'b0, 1'b0);
    send_char("j", 1'b0, 1'b1);

    // start row below the bottom with zero advance
    apply_setting(16'd4, 16'd40, 16'd28, 16'd30, 16'd0, 16'd8, 16'd2);
    send_char("k", 1'b1, 1'b0);
    send_char("l", 1'b0, 1'b0);
    send_char(CODE_NEWLINE, 1'b0, 1'b0);
    send_char("m", 1'b0, 1'b1);

    apply_setting(16'd0, 16'd0, 16'd40, 16'd40, 16'd8, 16'd8, 16'd2);
    random_text(PHASE_ITEMS);
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15, 16'd63, 16'd255);
    random_text(PHASE_ITEMS);

    wait_for_drain();
    src_idle_pct = 63;
    snk_idle_pct = 6;
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_text(PHASE_ITEMS);
    sx = $urandom_range(0, 300);
    sy = $urandom_range(0, 300);
    apply_setting(16'(sx), 16'(sy), 16'(sx + $urandom_range(0, 400)),
                  16'(sy + $urandom_range(0, 400)), 16'($urandom_range(0, 15)),
                  16'($urandom_range(0, 63)), 16'($urandom_range(0, 31)));
    random_text(PHASE_ITEMS);

    wait_for_drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // upper data bits beyond the register widths are dropped
    apply_setting(16'd3, 16'd2, 16'd20, 16'd10, 16'hFFF1, 16'hFFC1, 16'd0);
    random_text(PHASE_ITEMS);
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    random_text(PHASE_ITEMS);
    apply_setting(16'd16, 16'd8, 16'd200, 16'd120, 16'd6, 16'd10, 16'd3);
    random_text(PHASE_ITEMS);

    wait_for_drain();
    $display("run covered %0d characters and %0d register writes under three idle patterns",
             chars_sent, cfg_writes);
    $display("%0d glyphs drawn, %0d results reported clipped", drawn_seen, clipped_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
